### hw/rtl/slmu_pkg.sv
// Shared types, codes and constant tables of the lattice mat update block.
// No dependencies; every other file of the block depends on this package.
package slmu_pkg;

	localparam int COORD_W     = 10;
	localparam int DIR_W       = 3;
	localparam int GRID_SIDE_W = 11;
	localparam int COUNT_W     = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int CAUSE_W     = 2;

	localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RESET = 11'd1024;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REM_FIRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REM_SECOND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REM_THIRD = 3'd5;

	// Item modes.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_EVENT = 1'b1;

	// Compare slots of the shared comparator, one per draw.
	localparam int NUM_SLOTS = 5;
	localparam int SLOT_W    = 3;
	localparam logic [SLOT_W-1:0] SLOT_SETTLE     = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_GROW       = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_REM_FIRST  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_REM_SECOND = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_REM_THIRD  = 3'd4;

	// Removal causes.
	localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_FIRST  = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_SECOND = 2'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_THIRD  = 2'd3;

	// Coordinate step codes of a neighbor offset.
	localparam logic [1:0] STEP_HOLD = 2'd0;
	localparam logic [1:0] STEP_DEC  = 2'd1;
	localparam logic [1:0] STEP_INC  = 2'd2;

	// Control bits of the grid memory port.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_bit;
	} grid_ctl_t;

	// Row step of each of the eight neighbor directions.
	function automatic logic [1:0] row_step(input logic [DIR_W-1:0] dir);
		logic [1:0] s;
		unique case (dir)
			3'd0, 3'd3, 3'd5: s = STEP_DEC;
			3'd2, 3'd4, 3'd7: s = STEP_INC;
			default:          s = STEP_HOLD;
		endcase
		return s;
	endfunction

	// Column step of each of the eight neighbor directions.
	function automatic logic [1:0] col_step(input logic [DIR_W-1:0] dir);
		logic [1:0] s;
		unique case (dir)
			3'd0, 3'd1, 3'd2: s = STEP_DEC;
			3'd5, 3'd6, 3'd7: s = STEP_INC;
			default:          s = STEP_HOLD;
		endcase
		return s;
	endfunction

endpackage

### hw/rtl/slmu_ifs.sv
// Handshake channels of the lattice mat update block: items, results, configuration.
// Depends on slmu_pkg for the fixed field widths.
interface slmu_item_if #(parameter int DRAW_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [slmu_pkg::COORD_W-1:0]     row;
	logic [slmu_pkg::COORD_W-1:0]     column;
	logic [slmu_pkg::DIR_W-1:0]       direction;
	logic                             load_value;
	logic [DRAW_BITS-1:0]             settle_draw;
	logic [DRAW_BITS-1:0]             grow_draw;
	logic [DRAW_BITS-1:0]             first_removal_draw;
	logic [DRAW_BITS-1:0]             second_removal_draw;
	logic [DRAW_BITS-1:0]             third_removal_draw;

	modport source (output valid, mode, row, column, direction, load_value, settle_draw,
		grow_draw, first_removal_draw, second_removal_draw, third_removal_draw,
		input ready);
	modport sink (input valid, mode, row, column, direction, load_value, settle_draw,
		grow_draw, first_removal_draw, second_removal_draw, third_removal_draw,
		output ready);
endinterface

interface slmu_result_if;
	logic                             valid;
	logic                             ready;
	logic                             focal_after;
	logic                             neighbor_after;
	logic                             settled;
	logic                             grew;
	logic [slmu_pkg::CAUSE_W-1:0]     removal_cause;
	logic [slmu_pkg::COUNT_W-1:0]     mat_cells;
	logic [slmu_pkg::COUNT_W-1:0]     empty_cells;
	logic                             ignored;

	modport source (output valid, focal_after, neighbor_after, settled, grew, removal_cause,
		mat_cells, empty_cells, ignored, input ready);
	modport sink (input valid, focal_after, neighbor_after, settled, grew, removal_cause,
		mat_cells, empty_cells, ignored, output ready);
endinterface

interface slmu_cfg_if #(parameter int DATA_W = 17);
	logic                             valid;
	logic                             ready;
	logic [slmu_pkg::CFG_IDX_W-1:0]   index;
	logic [DATA_W-1:0]                data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/slmu_cmp.sv
// Shared threshold comparator: one draw against its threshold per cycle.
// Depends on slmu_pkg for the slot codes.
module slmu_cmp #(
	parameter int DRAW_BITS = 16
) (
	input  logic [slmu_pkg::SLOT_W-1:0]                   slot,
	input  logic [slmu_pkg::NUM_SLOTS-1:0][DRAW_BITS-1:0] draws,
	input  logic [slmu_pkg::NUM_SLOTS-1:0][DRAW_BITS:0]   thrs,
	output logic                                          hit
);
	import slmu_pkg::*;

	logic [DRAW_BITS:0] draw_sel;
	logic [DRAW_BITS:0] thr_sel;

	always_comb begin
		draw_sel = '0;
		thr_sel  = '0;
		if (slot < SLOT_W'(NUM_SLOTS)) begin
			draw_sel = {1'b0, draws[slot]};
			thr_sel  = thrs[slot];
		end
	end

	// A draw hits when it lies strictly below the threshold.
	assign hit = draw_sel < thr_sel;

endmodule

### hw/rtl/slmu_grid_mem.sv
// Cell grid memory: one row per word, single-bit writes, registered one-bit reads.
// Depends on slmu_pkg for the control struct; runs a row-per-cycle clearing pass after reset.
module slmu_grid_mem #(
	parameter int SIDE  = 1024,
	parameter int ROW_W = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slmu_pkg::grid_ctl_t   ctl,
	input  logic [ROW_W-1:0]      rd_row,
	input  logic [ROW_W-1:0]      rd_col,
	input  logic [ROW_W-1:0]      wr_row,
	input  logic [ROW_W-1:0]      wr_col,
	output logic                  rd_bit,
	output logic                  clear_done
);
	import slmu_pkg::*;

	logic [SIDE-1:0]  grid_q [SIDE];
	logic [ROW_W-1:0] clr_row_q;
	logic             clr_busy_q;
	logic             rd_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_row_q == ROW_W'(SIDE - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			grid_q[clr_row_q] <= '0;
		end else if (ctl.wr_en) begin
			grid_q[wr_row][wr_col] <= ctl.wr_bit;
		end
		if (ctl.rd_en) begin
			rd_bit_q <= grid_q[rd_row][rd_col];
		end
	end

	assign rd_bit     = rd_bit_q;
	assign clear_done = !clr_busy_q;

endmodule

### hw/rtl/stochastic_lattice_mat_update_top.sv
// Stochastic lattice mat update: top level with the sequencer, counts and config registers.
// Depends on slmu_pkg, the channel interfaces, slmu_cmp and slmu_grid_mem.
//
// The block keeps a square toroidal grid of one-bit cells (empty or mat) and a running
// count of mat cells. Items arrive on the item channel and each produces exactly one result
// item on the result channel; both use valid/ready and move an item when both are high.
// A load item writes one cell; an event item may settle an empty focal cell, grow a mat
// focal cell into its neighbor and then clear it by one of three removal draws.
// Configuration registers are written on the cfg channel, which is always ready; write
// them only while no item is in flight.
// An event or load item passes the states check, focal read, neighbor read, compare,
// neighbor write, focal write and output; the result is registered as it leaves output.
// An item outside the grid side goes from the focal read straight to output; the next
// item is taken only back in idle. The steps follow from the single memory port (focal read,
// neighbor read and write, focal write) and one comparator judging the five draws in turn.
// After reset the grid memory is cleared one row per cycle, all MAX_SIDE rows; the
// item channel is not ready until that pass ends, while config writes are taken at once.
// The result sits in an output register until taken. A new item is accepted while it
// waits, but the block holds its next result until the receiver has taken the old one.
module stochastic_lattice_mat_update_top #(
	parameter int MAX_SIDE  = 1024,
	parameter int DRAW_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	slmu_item_if.sink   item,
	slmu_result_if.source result,
	slmu_cfg_if.sink    cfg
);
	import slmu_pkg::*;

	// Coordinate widths follow the largest grid; CW also holds the 11-bit side register.
	localparam int ROW_W  = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CW     = (SIDE_W > GRID_SIDE_W) ? SIDE_W : GRID_SIDE_W;
	localparam int AREA_W = 2 * CW;
	localparam int EW     = (AREA_W > COUNT_W) ? AREA_W : COUNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_RDF  = 3'd2;
	localparam logic [2:0] S_RDN  = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_WRN  = 3'd5;
	localparam logic [2:0] S_WRF  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	// Configuration registers.
	logic [GRID_SIDE_W-1:0]               grid_side_q;
	logic [NUM_SLOTS-1:0][DRAW_BITS:0]    thr_q;

	// Sequencer and counts.
	logic [2:0]          state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  mat_q;
	logic                res_valid_q;

	// Item held for the whole run.
	logic                                 mode_q;
	logic [COORD_W-1:0]                   row_q;
	logic [COORD_W-1:0]                   col_q;
	logic [DIR_W-1:0]                     dir_q;
	logic                                 lv_q;
	logic [NUM_SLOTS-1:0][DRAW_BITS-1:0]  draws_q;

	// Working values of the run.
	logic                  ign_q;
	logic [CW-1:0]         nrow_q;
	logic [CW-1:0]         ncol_q;
	logic                  f0_q;
	logic                  n0_q;
	logic [NUM_SLOTS-1:0]  hits_q;
	logic                  grew_q;
	logic                  settled_q;
	logic [CAUSE_W-1:0]    cause_q;
	logic                  ff_q;
	logic [AREA_W-1:0]     area_q;

	// Result register.
	logic                  res_focal_q;
	logic                  res_neigh_q;
	logic                  res_settled_q;
	logic                  res_grew_q;
	logic [CAUSE_W-1:0]    res_cause_q;
	logic [COUNT_W-1:0]    res_mat_q;
	logic [COUNT_W-1:0]    res_empty_q;
	logic                  res_ign_q;

	logic [CW-1:0]         side_c;
	logic [CW-1:0]         row_c;
	logic [CW-1:0]         col_c;
	logic                  out_of_grid;
	logic                  same_cell;
	logic                  grow_now;
	logic                  focal_wr;
	logic                  focal_new;
	logic [CAUSE_W-1:0]    cause_new;
	logic [EW-1:0]         area_e;
	logic [EW-1:0]         mat_e;
	logic [EW-1:0]         empty_e;
	logic                  res_load;
	logic                  cmp_hit;
	logic                  rd_bit;
	logic                  clear_done;
	grid_ctl_t             gctl;
	logic [ROW_W-1:0]      rd_row;
	logic [ROW_W-1:0]      rd_col;
	logic [ROW_W-1:0]      wr_row;
	logic [ROW_W-1:0]      wr_col;

	// One wraparound step on the side in use; its result is used only for coordinates inside the grid.
	function automatic logic [CW-1:0] wrap_coord(input logic [CW-1:0] v,
		input logic [1:0] step, input logic [CW-1:0] side);
		logic [CW-1:0] inc;
		logic [CW-1:0] res;
		inc = v + CW'(1);
		case (step)
			STEP_DEC: res = (v == '0) ? side - CW'(1) : v - CW'(1);
			STEP_INC: res = (inc >= side) ? '0 : inc;
			default:  res = v;
		endcase
		return res;
	endfunction

	// The side in use saturates at the largest grid the memory holds.
	assign side_c = (CW'(grid_side_q) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(grid_side_q);
	assign row_c  = CW'(row_q);
	assign col_c  = CW'(col_q);
	assign out_of_grid = (row_c >= side_c) || (col_c >= side_c);
	// Only a grid of side one folds the neighbor back onto the focal cell.
	assign same_cell = (nrow_q == row_c) && (ncol_q == col_c);

	// Growth needs a mat focal cell and an empty neighbor before the event.
	assign grow_now = (mode_q == MODE_EVENT) && f0_q && !n0_q && hits_q[SLOT_GROW];

	// The result register loads once the previous result is gone or leaves this cycle.
	assign res_load = (state_q == S_OUT) && (!res_valid_q || result.ready);

	// The first removal draw below its threshold decides the cause.
	always_comb begin
		if (hits_q[SLOT_REM_FIRST]) begin
			cause_new = CAUSE_FIRST;
		end else if (hits_q[SLOT_REM_SECOND]) begin
			cause_new = CAUSE_SECOND;
		end else if (hits_q[SLOT_REM_THIRD]) begin
			cause_new = CAUSE_THIRD;
		end else begin
			cause_new = CAUSE_NONE;
		end
	end

	// Focal write: a load writes its value, an empty focal cell may settle, a mat one may
	// be cleared.
	always_comb begin
		if (mode_q == MODE_LOAD) begin
			focal_new = lv_q;
			focal_wr  = (f0_q != lv_q);
		end else if (!f0_q) begin
			focal_new = 1'b1;
			focal_wr  = hits_q[SLOT_SETTLE];
		end else begin
			focal_new = 1'b0;
			focal_wr  = (cause_new != CAUSE_NONE);
		end
	end

	// Empty count is the area less the mat count, floored at zero.
	assign area_e  = EW'(area_q);
	assign mat_e   = EW'(mat_q);
	assign empty_e = (area_e > mat_e) ? area_e - mat_e : '0;

	// Memory port addressing by sequencer step.
	always_comb begin
		gctl   = '0;
		rd_row = row_c[ROW_W-1:0];
		rd_col = col_c[ROW_W-1:0];
		wr_row = row_c[ROW_W-1:0];
		wr_col = col_c[ROW_W-1:0];
		unique case (state_q)
			S_RDF: begin
				gctl.rd_en = !ign_q;
			end
			S_RDN: begin
				gctl.rd_en = 1'b1;
				rd_row     = nrow_q[ROW_W-1:0];
				rd_col     = ncol_q[ROW_W-1:0];
			end
			S_WRN: begin
				gctl.wr_en  = grow_now;
				gctl.wr_bit = 1'b1;
				wr_row      = nrow_q[ROW_W-1:0];
				wr_col      = ncol_q[ROW_W-1:0];
			end
			S_WRF: begin
				gctl.wr_en  = focal_wr;
				gctl.wr_bit = focal_new;
			end
			default: begin
			end
		endcase
	end

	slmu_grid_mem #(
		.SIDE  (MAX_SIDE),
		.ROW_W (ROW_W)
	) u_grid (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (gctl),
		.rd_row     (rd_row),
		.rd_col     (rd_col),
		.wr_row     (wr_row),
		.wr_col     (wr_col),
		.rd_bit     (rd_bit),
		.clear_done (clear_done)
	);

	slmu_cmp #(
		.DRAW_BITS (DRAW_BITS)
	) u_cmp (
		.slot  (slot_q),
		.draws (draws_q),
		.thrs  (thr_q),
		.hit   (cmp_hit)
	);

	// Control state, counts and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			mat_q       <= '0;
			res_valid_q <= 1'b0;
			grid_side_q <= GRID_SIDE_RESET;
			thr_q       <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_GRID_SIDE:  grid_side_q <= cfg.data[GRID_SIDE_W-1:0];
					CFG_SETTLE:     thr_q[SLOT_SETTLE] <= cfg.data[DRAW_BITS:0];
					CFG_GROW:       thr_q[SLOT_GROW] <= cfg.data[DRAW_BITS:0];
					CFG_REM_FIRST:  thr_q[SLOT_REM_FIRST] <= cfg.data[DRAW_BITS:0];
					CFG_REM_SECOND: thr_q[SLOT_REM_SECOND] <= cfg.data[DRAW_BITS:0];
					CFG_REM_THIRD:  thr_q[SLOT_REM_THIRD] <= cfg.data[DRAW_BITS:0];
					default: begin
					end
				endcase
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid && item.ready) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= S_RDF;
				end
				S_RDF: begin
					state_q <= ign_q ? S_OUT : S_RDN;
				end
				S_RDN: begin
					slot_q  <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (slot_q == SLOT_W'(NUM_SLOTS - 1)) begin
						state_q <= S_WRN;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_WRN: begin
					if (grow_now) begin
						mat_q <= mat_q + 1'b1;
					end
					state_q <= S_WRF;
				end
				S_WRF: begin
					if (focal_wr) begin
						mat_q <= focal_new ? mat_q + 1'b1 : mat_q - 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold here while an earlier result still waits to be taken.
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and working values of the run.
	always_ff @(posedge clk) begin
		area_q <= AREA_W'(side_c) * AREA_W'(side_c);
		unique case (state_q)
			S_IDLE: begin
				if (item.valid && item.ready) begin
					mode_q                   <= item.mode;
					row_q                    <= item.row;
					col_q                    <= item.column;
					dir_q                    <= item.direction;
					lv_q                     <= item.load_value;
					draws_q[SLOT_SETTLE]     <= item.settle_draw;
					draws_q[SLOT_GROW]       <= item.grow_draw;
					draws_q[SLOT_REM_FIRST]  <= item.first_removal_draw;
					draws_q[SLOT_REM_SECOND] <= item.second_removal_draw;
					draws_q[SLOT_REM_THIRD]  <= item.third_removal_draw;
				end
			end
			S_CHK: begin
				ign_q     <= out_of_grid;
				nrow_q    <= wrap_coord(row_c, row_step(dir_q), side_c);
				ncol_q    <= wrap_coord(col_c, col_step(dir_q), side_c);
				grew_q    <= 1'b0;
				settled_q <= 1'b0;
				cause_q   <= CAUSE_NONE;
				ff_q      <= 1'b0;
			end
			S_RDN: begin
				f0_q <= rd_bit;
			end
			S_CMP: begin
				if (slot_q == SLOT_SETTLE) begin
					n0_q <= rd_bit;
				end
				hits_q[slot_q] <= cmp_hit;
			end
			S_WRN: begin
				grew_q <= grow_now;
			end
			S_WRF: begin
				ff_q      <= focal_wr ? focal_new : f0_q;
				settled_q <= (mode_q == MODE_EVENT) && !f0_q && hits_q[SLOT_SETTLE];
				cause_q   <= ((mode_q == MODE_EVENT) && f0_q) ? cause_new : CAUSE_NONE;
			end
			S_OUT: begin
				if (res_load) begin
					res_focal_q   <= ff_q;
					res_neigh_q   <= ((mode_q == MODE_EVENT) && !ign_q) ?
						(same_cell ? ff_q : (n0_q | grew_q)) : 1'b0;
					res_settled_q <= settled_q;
					res_grew_q    <= grew_q;
					res_cause_q   <= cause_q;
					res_mat_q     <= mat_q;
					res_empty_q   <= empty_e[COUNT_W-1:0];
					res_ign_q     <= ign_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign item.ready = (state_q == S_IDLE) && clear_done;
	assign cfg.ready  = 1'b1;

	assign result.valid          = res_valid_q;
	assign result.focal_after    = res_focal_q;
	assign result.neighbor_after = res_neigh_q;
	assign result.settled        = res_settled_q;
	assign result.grew           = res_grew_q;
	assign result.removal_cause  = res_cause_q;
	assign result.mat_cells      = res_mat_q;
	assign result.empty_cells    = res_empty_q;
	assign result.ignored        = res_ign_q;

	// The grid is never written while the clearing pass still runs.
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		gctl.wr_en |-> clear_done)
		else $error("grid write during clearing pass");

	// The mat count moves by at most one cell per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_q == $past(mat_q)) || ((mat_q - $past(mat_q)) == COUNT_W'(1)) ||
		(($past(mat_q) - mat_q) == COUNT_W'(1)))
		else $error("mat count jumped");

	// An ignored item reports no cell change.
	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ignored) |-> (!result.focal_after &&
		!result.neighbor_after && !result.settled && !result.grew &&
		(result.removal_cause == CAUSE_NONE)))
		else $error("ignored item reports a change");

	// Settling and growth exclude each other: they need opposite focal values.
	a_settle_grow: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.settled && result.grew))
		else $error("settled and grew in one item");

endmodule

### sim/tb_stochastic_lattice_mat_update_top.sv
// Self-checking testbench of stochastic_lattice_mat_update_top: directed and random items.
// Depends on slmu_pkg, the slmu channel interfaces and the block's RTL. It reads no files.
// A built-in grid predictor holds the expected result of every accepted item.
module tb_stochastic_lattice_mat_update_top;
	timeunit 1ns;
	timeprecision 1ps;

	import slmu_pkg::*;

	localparam int MAX_SIDE        = 1024;
	localparam int DRAW_BITS       = 16;
	localparam int THR_W           = 17;
	localparam int RANDOM_PHASES   = 11;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PRESSURE_PHASE  = 2;
	localparam int LONG_HOLD       = 300;
	// Extra wait after the last result so the block is surely idle; leave some margin.
	localparam int QUIET_CYCLES    = 16;
	localparam int REPORT_LIMIT    = 10;

	// Neighbor directions, named after the compass with row growing southward.
	localparam logic [DIR_W-1:0] DIR_NW   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_WEST = 3'd1;
	localparam logic [DIR_W-1:0] DIR_SW   = 3'd2;
	localparam logic [DIR_W-1:0] DIR_N    = 3'd3;
	localparam logic [DIR_W-1:0] DIR_S    = 3'd4;
	localparam logic [DIR_W-1:0] DIR_NE   = 3'd5;
	localparam logic [DIR_W-1:0] DIR_E    = 3'd6;
	localparam logic [DIR_W-1:0] DIR_SE   = 3'd7;

	localparam int ROW_OFFSET [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
	localparam int COL_OFFSET [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

	// Threshold values of interest: never a hit, always a hit, all bits set, half.
	localparam logic [THR_W-1:0] THR_NEVER  = 17'h00000;
	localparam logic [THR_W-1:0] THR_ALWAYS = 17'h10000;
	localparam logic [THR_W-1:0] THR_ONES   = 17'h1FFFF;
	localparam logic [THR_W-1:0] THR_HALF   = 17'h08000;

	typedef struct packed {
		logic                            mode;
		logic [COORD_W-1:0]              row;
		logic [COORD_W-1:0]              column;
		logic [DIR_W-1:0]                direction;
		logic                            load_value;
		logic [DRAW_BITS-1:0]            settle_draw;
		logic [DRAW_BITS-1:0]            grow_draw;
		logic [2:0][DRAW_BITS-1:0]       removal_draw;
	} lattice_item_t;

	typedef struct packed {
		logic                 focal_after;
		logic                 neighbor_after;
		logic                 settled;
		logic                 grew;
		logic [CAUSE_W-1:0]   removal_cause;
		logic [COUNT_W-1:0]   mat_cells;
		logic [COUNT_W-1:0]   empty_cells;
		logic                 ignored;
	} lattice_outcome_t;

	// Mirror of the lattice and its registers, plus the outcomes still owed by the block.
	class mat_scoreboard;
		bit [MAX_SIDE-1:0]     cells [MAX_SIDE];
		logic [COUNT_W-1:0]    mat_total;
		logic [GRID_SIDE_W-1:0] grid_side;
		logic [THR_W-1:0]      settle_thr;
		logic [THR_W-1:0]      grow_thr;
		logic [THR_W-1:0]      removal_thr [3];
		lattice_outcome_t      pending_outcomes [$];
		int unsigned           mismatches;

		function new();
			foreach (cells[r])
				cells[r] = '0;
			mat_total = '0;
			grid_side = GRID_SIDE_RESET;
			settle_thr = THR_NEVER;
			grow_thr = THR_NEVER;
			foreach (removal_thr[k])
				removal_thr[k] = THR_NEVER;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
			case (idx)
				CFG_GRID_SIDE:  grid_side = value[GRID_SIDE_W-1:0];
				CFG_SETTLE:     settle_thr = value;
				CFG_GROW:       grow_thr = value;
				CFG_REM_FIRST:  removal_thr[0] = value;
				CFG_REM_SECOND: removal_thr[1] = value;
				CFG_REM_THIRD:  removal_thr[2] = value;
				default: ;
			endcase
		endfunction

		// Sides beyond the memory saturate at its size.
		function int unsigned side_in_use();
			return (grid_side > MAX_SIDE) ? MAX_SIDE : int'(grid_side);
		endfunction

		// One step along a torus axis of the given side.
		function int unsigned wrap_coord(int unsigned v, int d, int unsigned side);
			if (d < 0)
				return (v == 0) ? side - 1 : v - 1;
			if (d > 0)
				return (v + 1 >= side) ? 0 : v + 1;
			return v;
		endfunction

		function lattice_outcome_t apply_update(lattice_item_t it);
			lattice_outcome_t r;
			int unsigned side, nr, nc, area;
			bit focal_was, neighbor_was;
			logic [CAUSE_W-1:0] causes [3];
			causes = '{CAUSE_FIRST, CAUSE_SECOND, CAUSE_THIRD};
			r = '0;
			r.removal_cause = CAUSE_NONE;
			side = side_in_use();
			nr = 0;
			nc = 0;
			if (it.row >= side || it.column >= side) begin
				r.ignored = 1'b1;
			end else if (it.mode == MODE_LOAD) begin
				if (cells[it.row][it.column] != it.load_value) begin
					mat_total = it.load_value ? mat_total + 1'b1 : mat_total - 1'b1;
					cells[it.row][it.column] = it.load_value;
				end
				r.focal_after = it.load_value;
			end else begin
				nr = wrap_coord(it.row, ROW_OFFSET[it.direction], side);
				nc = wrap_coord(it.column, COL_OFFSET[it.direction], side);
				focal_was = cells[it.row][it.column];
				neighbor_was = cells[nr][nc];
				if (!focal_was) begin
					// An empty focal cell only looks at its settle draw.
					if (it.settle_draw < settle_thr) begin
						cells[it.row][it.column] = 1'b1;
						mat_total = mat_total + 1'b1;
						r.settled = 1'b1;
					end
				end else begin
					if (!neighbor_was && it.grow_draw < grow_thr) begin
						cells[nr][nc] = 1'b1;
						mat_total = mat_total + 1'b1;
						r.grew = 1'b1;
					end
					for (int k = 0; k < 3; k++) begin
						if (it.removal_draw[k] < removal_thr[k]) begin
							cells[it.row][it.column] = 1'b0;
							mat_total = mat_total - 1'b1;
							r.removal_cause = causes[k];
							break;
						end
					end
				end
				r.focal_after = cells[it.row][it.column];
				r.neighbor_after = cells[nr][nc];
			end
			area = side * side;
			r.mat_cells = mat_total;
			r.empty_cells = (area > mat_total) ? COUNT_W'(area - mat_total) : '0;
			return r;
		endfunction

		function void take_item(lattice_item_t it);
			pending_outcomes.push_back(apply_update(it));
		endfunction

		function void judge_result(lattice_outcome_t got);
			lattice_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result arrived with nothing pending: mat %0d empty %0d",
						$time, got.mat_cells, got.empty_cells);
				return;
			end
			want = pending_outcomes.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: mismatch (expected/actual): focal %0d/%0d neighbor %0d/%0d",
						$time, want.focal_after, got.focal_after, want.neighbor_after,
						got.neighbor_after);
					$display("    settled %0d/%0d grew %0d/%0d cause %0d/%0d mat %0d/%0d",
						want.settled, got.settled, want.grew, got.grew,
						want.removal_cause, got.removal_cause, want.mat_cells, got.mat_cells);
					$display("    empty %0d/%0d ignored %0d/%0d",
						want.empty_cells, got.empty_cells, want.ignored, got.ignored);
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending_outcomes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	slmu_item_if #(.DRAW_BITS(DRAW_BITS)) item_ch();
	slmu_result_if                       result_ch();
	slmu_cfg_if #(.DATA_W(THR_W))        cfg_ch();

	stochastic_lattice_mat_update_top #(
		.MAX_SIDE(MAX_SIDE),
		.DRAW_BITS(DRAW_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	mat_scoreboard board = new();

	// Knobs shared by the sender and the receiver. In the calm stretch at the end of
	// the run neither side idles; hold_request asks the receiver for one long hold-off.
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned send_idle_pct = 30;
	int unsigned take_stall_pct = 20;

	always #2 clk = ~clk;

	// Offers one item and waits for the handshake. The predictor is updated at the
	// edge that takes the item. Afterward the sender may idle for a short burst;
	// otherwise valid stays high so the next item follows back to back.
	task automatic offer_item(input lattice_item_t it);
		item_ch.valid <= 1'b1;
		item_ch.mode <= it.mode;
		item_ch.row <= it.row;
		item_ch.column <= it.column;
		item_ch.direction <= it.direction;
		item_ch.load_value <= it.load_value;
		item_ch.settle_draw <= it.settle_draw;
		item_ch.grow_draw <= it.grow_draw;
		item_ch.first_removal_draw <= it.removal_draw[0];
		item_ch.second_removal_draw <= it.removal_draw[1];
		item_ch.third_removal_draw <= it.removal_draw[2];
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		board.take_item(it);
		if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stops offering items and waits until the block has returned every result it owes,
	// plus a few cycles so that it is surely idle before registers change.
	task automatic wait_quiet();
		item_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		board.set_reg(idx, value);
	endtask

	// Writes the whole register set back to back, then releases the channel.
	task automatic program_regs(input logic [THR_W-1:0] side, input logic [THR_W-1:0] settle,
		input logic [THR_W-1:0] grow, input logic [THR_W-1:0] rem_first,
		input logic [THR_W-1:0] rem_second, input logic [THR_W-1:0] rem_third);
		write_reg(CFG_GRID_SIDE, side);
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_GROW, grow);
		write_reg(CFG_REM_FIRST, rem_first);
		write_reg(CFG_REM_SECOND, rem_second);
		write_reg(CFG_REM_THIRD, rem_third);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic lattice_item_t make_item(logic mode, int unsigned row, int unsigned column,
		logic [DIR_W-1:0] direction, logic load_value, logic [DRAW_BITS-1:0] settle_draw,
		logic [DRAW_BITS-1:0] grow_draw, logic [DRAW_BITS-1:0] first_draw,
		logic [DRAW_BITS-1:0] second_draw, logic [DRAW_BITS-1:0] third_draw);
		lattice_item_t it;
		it.mode = mode;
		it.row = COORD_W'(row);
		it.column = COORD_W'(column);
		it.direction = direction;
		it.load_value = load_value;
		it.settle_draw = settle_draw;
		it.grow_draw = grow_draw;
		it.removal_draw[0] = first_draw;
		it.removal_draw[1] = second_draw;
		it.removal_draw[2] = third_draw;
		return it;
	endfunction

	// Mostly events on cells inside the grid, a quarter loads to seed and clear mat, and on a
	// grid smaller than the memory about one item in ten lands off the grid. Draws cover their whole range.
	function automatic lattice_item_t random_item(int unsigned side_eff);
		lattice_item_t it;
		int unsigned r, c;
		it.mode = ($urandom_range(0, 99) < 25) ? MODE_LOAD : MODE_EVENT;
		it.direction = DIR_W'($urandom_range(0, 7));
		it.load_value = 1'($urandom_range(0, 1));
		it.settle_draw = DRAW_BITS'($urandom_range(0, 65535));
		it.grow_draw = DRAW_BITS'($urandom_range(0, 65535));
		foreach (it.removal_draw[k])
			it.removal_draw[k] = DRAW_BITS'($urandom_range(0, 65535));
		if (side_eff >= MAX_SIDE) begin
			r = $urandom_range(0, MAX_SIDE - 1);
			c = $urandom_range(0, MAX_SIDE - 1);
		end else if (side_eff > 0 && $urandom_range(0, 99) < 90) begin
			r = $urandom_range(0, side_eff - 1);
			c = $urandom_range(0, side_eff - 1);
		end else begin
			// At least one coordinate is off the grid.
			r = $urandom_range(side_eff, MAX_SIDE - 1);
			c = $urandom_range(0, MAX_SIDE - 1);
			if ($urandom_range(0, 1) == 1) begin
				it.row = COORD_W'(c);
				c = r;
				r = it.row;
			end
		end
		it.row = COORD_W'(r);
		it.column = COORD_W'(c);
		return it;
	endfunction

	// Thresholds are mostly uniform over the draw range, with the extremes now and then.
	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 9))
			0:       return THR_NEVER;
			1:       return THR_ALWAYS;
			2:       return THR_ONES;
			default: return THR_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Result side: checks every result that is taken and drives ready. Ready drops in
	// short random bursts, and once for a long hold-off so the block backs up and stops
	// taking items. All decisions are made right after the edge, for the next one.
	initial begin : result_taker
		int unsigned stall_left;
		int unsigned hold_left;
		lattice_outcome_t got;
		stall_left = 0;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.focal_after = result_ch.focal_after;
				got.neighbor_after = result_ch.neighbor_after;
				got.settled = result_ch.settled;
				got.grew = result_ch.grew;
				got.removal_cause = result_ch.removal_cause;
				got.mat_cells = result_ch.mat_cells;
				got.empty_cells = result_ch.empty_cells;
				got.ignored = result_ch.ignored;
				board.judge_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < take_stall_pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Item and register side: reset, the directed cases, then the random phases.
	initial begin : stimulus
		logic [THR_W-1:0] side_val;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_LOAD;
		item_ch.row <= '0;
		item_ch.column <= '0;
		item_ch.direction <= DIR_NW;
		item_ch.load_value <= 1'b0;
		item_ch.settle_draw <= '0;
		item_ch.grow_draw <= '0;
		item_ch.first_removal_draw <= '0;
		item_ch.second_removal_draw <= '0;
		item_ch.third_removal_draw <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_GRID_SIDE;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: full 1024 grid, every threshold zero. Corner cells, a load that
		// changes nothing, and events whose draws can never hit.
		offer_item(make_item(MODE_LOAD, 0, 0, DIR_NW, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_LOAD, 1023, 1023, DIR_SE, 1'b1,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer_item(make_item(MODE_LOAD, 1023, 1023, DIR_SE, 1'b1,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		// Wraps from the origin to the far corner.
		offer_item(make_item(MODE_EVENT, 0, 0, DIR_NW, 1'b0,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer_item(make_item(MODE_EVENT, 5, 5, DIR_SE, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

		// Shrink to a grid of side three with the far corner still counted in the mat
		// total. Settle and grow always hit.
		wait_quiet();
		program_regs(17'd3, THR_ALWAYS, THR_ALWAYS, THR_NEVER, THR_NEVER, THR_NEVER);
		offer_item(make_item(MODE_LOAD, 3, 0, DIR_NW, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_EVENT, 0, 1023, DIR_E, 1'b1,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_EVENT, 1, 1, DIR_E, 1'b0,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer_item(make_item(MODE_EVENT, 1, 1, DIR_E, 1'b0,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// An empty focal cell next to a mat neighbor across the wrap only settles.
		offer_item(make_item(MODE_EVENT, 2, 2, DIR_SE, 1'b0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

		// One item for each removal cause; the third threshold has all bits set.
		wait_quiet();
		program_regs(17'd3, THR_NEVER, THR_NEVER, THR_HALF, THR_HALF, THR_ONES);
		offer_item(make_item(MODE_EVENT, 1, 1, DIR_WEST, 1'b0,
			16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
		offer_item(make_item(MODE_EVENT, 1, 2, DIR_N, 1'b0,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000));
		offer_item(make_item(MODE_EVENT, 0, 0, DIR_NE, 1'b0,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF));
		offer_item(make_item(MODE_LOAD, 2, 2, DIR_NW, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

		// A zero side ignores even the origin.
		wait_quiet();
		program_regs(17'd0, THR_NEVER, THR_NEVER, THR_HALF, THR_HALF, THR_ONES);
		offer_item(make_item(MODE_LOAD, 0, 0, DIR_NW, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

		// On a single cell the neighbor is the focal cell itself, so nothing can grow.
		wait_quiet();
		program_regs(17'd1, THR_ALWAYS, THR_ALWAYS, THR_ALWAYS, THR_NEVER, THR_NEVER);
		offer_item(make_item(MODE_EVENT, 0, 0, DIR_NW, 1'b0,
			16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_EVENT, 0, 0, DIR_SE, 1'b0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0));

		// Side two: stepping either way reaches the same row.
		wait_quiet();
		program_regs(17'd2, THR_NEVER, THR_ALWAYS, THR_NEVER, THR_NEVER, THR_NEVER);
		offer_item(make_item(MODE_LOAD, 1, 1, DIR_NW, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_EVENT, 1, 1, DIR_S, 1'b0,
			16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

		// A side beyond the memory saturates at its size.
		wait_quiet();
		program_regs(17'd2047, THR_ALWAYS, THR_NEVER, THR_NEVER, THR_NEVER, THR_ONES);
		offer_item(make_item(MODE_EVENT, 1023, 0, DIR_SW, 1'b0,
			16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_LOAD, 1023, 1023, DIR_NW, 1'b0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		offer_item(make_item(MODE_EVENT, 1023, 1023, DIR_SE, 1'b0,
			16'h1234, 16'h0, 16'h0, 16'h0, 16'h0));

		// Random phases, each with its own register set. The first covers the full grid
		// so every coordinate bit toggles, the second a grid of side three, the last runs
		// with no idling at all. Most phases keep the grid small so mat builds up.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_quiet();
			calm = (ph == RANDOM_PHASES - 1);
			if (ph == 0)
				side_val = 17'd1024;
			else if (ph == 1)
				side_val = 17'd3;
			else if (calm)
				side_val = 17'd5;
			else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: side_val = THR_W'($urandom_range(3, 8));
					5:             side_val = THR_W'($urandom_range(9, 40));
					6:             side_val = 17'd1024;
					7:             side_val = THR_W'($urandom_range(1, 2));
					8:             side_val = THR_W'($urandom_range(1025, 2047));
					default:       side_val = THR_W'($urandom_range(3, 16));
				endcase
			end
			program_regs(side_val, pick_threshold(), pick_threshold(), pick_threshold(),
				pick_threshold(), pick_threshold());
			send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
			take_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
			// Keep items coming while the receiver holds off for a long stretch.
			if (ph == PRESSURE_PHASE) begin
				send_idle_pct = 0;
				hold_request = 1'b1;
			end
			repeat (ITEMS_PER_PHASE)
				offer_item(random_item(board.side_in_use()));
		end

		wait_quiet();
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("stochastic_lattice_mat_update_top verification clean");
		else
			$display("stochastic_lattice_mat_update_top verification failed");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin : watchdog
		#2000000;
		$display("stochastic_lattice_mat_update_top verification failed");
		$finish;
	end

endmodule

### sim.f
hw/rtl/slmu_pkg.sv
hw/rtl/slmu_ifs.sv
hw/rtl/slmu_cmp.sv
hw/rtl/slmu_grid_mem.sv
hw/rtl/stochastic_lattice_mat_update_top.sv
sim/tb_stochastic_lattice_mat_update_top.sv
